>>> sv/grd_pkg.sv
`default_nettype none
package grd_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_CELL_WIDTH  = 3'd0;
    localparam logic [2:0] REG_CELL_HEIGHT = 3'd1;
    localparam logic [2:0] REG_MAP_COLUMNS = 3'd2;
    localparam logic [2:0] REG_MAP_ROWS    = 3'd3;
    localparam logic [2:0] REG_MAX_LENGTH  = 3'd4;

    localparam logic [0:0] CMD_WRITE = 1'b0;
    localparam logic [0:0] CMD_CAST  = 1'b1;

    localparam logic [31:0] SIDE_MAX    = 32'hFFFF_FFFF;
    localparam logic [19:0] LEN_OUT_MAX = 20'hF_FFFF;

    // results of one axis setup
    typedef struct packed {
        logic        busy;
        logic        neg;
        logic [11:0] origin;
        logic [31:0] step;
        logic [31:0] side;
    } grd_axis_t;

endpackage
`default_nettype wire

>>> sv/grd_div.sv
`default_nettype none
module grd_div
    import grd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] quo_reg;
    logic [16:0] rem_reg;
    logic [15:0] dsr_reg;
    logic [16:0] rem_sh;
    logic        take;

    // restoring, one quotient bit a cycle; a zero divisor gives all ones
    always_comb
    begin
        rem_sh = {rem_reg[15:0], quo_reg[31]};
        take   = rem_sh >= {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[30:0], take};
            rem_reg <= take ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

>>> sv/grd_axis.sv
`default_nettype none
module grd_axis
    import grd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [19:0]        pos,
    input  wire logic [8:0]         cell_size,
    input  wire logic signed [15:0] dir,
    output grd_axis_t               res
);

    typedef enum logic [2:0] {
        A_IDLE,
        A_DIV_CELL,
        A_FRAC,
        A_DIV_STEP,
        A_DIV_SIDE
    } axis_state_t;

    axis_state_t state_reg;
    logic [19:0] pos_reg;
    logic [8:0]  cellv_reg;
    logic [15:0] mag_reg;
    logic        neg_reg;
    logic [11:0] c_reg;
    logic [16:0] frac_reg;
    logic [31:0] step_reg;
    logic [31:0] side_reg;

    logic        div_start;
    logic [31:0] div_dividend;
    logic [15:0] div_divisor;
    logic        div_done;
    logic [31:0] div_quo;
    logic [8:0]  cellv_in;
    logic [16:0] cpix;
    logic [16:0] side_num;
    logic [20:0] prod;

    assign cellv_in = (cell_size == 9'd0) ? 9'd1 : cell_size;
    assign cpix     = {cellv_reg, 8'd0};
    assign side_num = neg_reg ? frac_reg : (cpix - frac_reg);
    assign prod     = c_reg * cellv_reg;

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = {20'd0, pos[19:8]};
        div_divisor  = {7'd0, cellv_in};
        case (state_reg)
            A_IDLE:
            begin
                div_start = start;
            end
            A_FRAC:
            begin
                div_start    = 1'b1;
                div_dividend = {cpix, 15'd0};
                div_divisor  = mag_reg;
            end
            A_DIV_STEP:
            begin
                div_start    = div_done;
                div_dividend = {side_num, 15'd0};
                div_divisor  = mag_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    grd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
        end
        else
        begin
            case (state_reg)
                A_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= A_DIV_CELL;
                    end
                end
                A_DIV_CELL:
                begin
                    if (div_done)
                    begin
                        state_reg <= A_FRAC;
                    end
                end
                A_FRAC:
                begin
                    state_reg <= A_DIV_STEP;
                end
                A_DIV_STEP:
                begin
                    if (div_done)
                    begin
                        state_reg <= A_DIV_SIDE;
                    end
                end
                A_DIV_SIDE:
                begin
                    if (div_done)
                    begin
                        state_reg <= A_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == A_IDLE && start)
        begin
            pos_reg   <= pos;
            cellv_reg <= cellv_in;
            neg_reg   <= dir[15];
            mag_reg   <= dir[15] ? (~dir + 16'd1) : dir;
        end
        if (state_reg == A_DIV_CELL && div_done)
        begin
            c_reg <= div_quo[11:0];
        end
        if (state_reg == A_FRAC)
        begin
            frac_reg <= 17'(pos_reg - {prod[11:0], 8'd0});
        end
        if (state_reg == A_DIV_STEP && div_done)
        begin
            step_reg <= div_quo;
        end
        if (state_reg == A_DIV_SIDE && div_done)
        begin
            side_reg <= div_quo;
        end
    end

    // busy, neg, origin, step, side
    assign res = {state_reg != A_IDLE, neg_reg, c_reg, step_reg, side_reg};

endmodule
`default_nettype wire

>>> sv/grd_tile_mem.sv
`default_nettype none
module grd_tile_mem
    import grd_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic          wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic               rdata,
    output logic               clearing
);

    logic          mem [DEPTH];
    logic          clr_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          rdata_reg;

    // clearing pass after reset, one entry a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(DEPTH - 1))
            begin
                clr_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_reg)
        begin
            mem[clr_cnt_reg] <= 1'b0;
        end
        else if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata    = rdata_reg;
    assign clearing = clr_reg;

endmodule
`default_nettype wire

>>> sv/grid_ray_dda_traversal.sv
// tile write: no result
// cast: setup of three divisions per axis, both axes in parallel, then per visited cell
// the steps test, step, address, tile memory read and check
// one item at a time; after the last test the result goes through S_OUT into the
// output register and is held there; after reset all MAX_COLUMNS*MAX_ROWS tile memory
// entries are cleared with no item accepted; configuration returns to reset values at once
`default_nettype none
module grid_ray_dda_traversal
    import grd_pkg::*;
#(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tile_index, tile_solid, start_x, start_y, dir_x, dir_y, zero pad
    input  wire logic [87:0] s_axis_tdata,
    // cmd
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // ray_length, hit, zero pad
    output logic [23:0]      m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [19:0] cfg_data
);

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CLW   = $clog2(MAX_COLUMNS + 1);
    localparam int RLW   = $clog2(MAX_ROWS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_TEST,
        S_STEP,
        S_ADDR,
        S_READ,
        S_CHECK,
        S_OUT
    } state_t;

    state_t state_reg;

    logic [8:0]  cell_width_reg;
    logic [8:0]  cell_height_reg;
    logic [6:0]  map_columns_reg;
    logic [6:0]  map_rows_reg;
    logic [19:0] max_length_reg;

    logic [CLW-1:0]     cols_reg;
    logic [RLW-1:0]     rows_reg;
    logic [19:0]        max_reg;
    logic signed [15:0] cx_reg;
    logic signed [15:0] cy_reg;
    logic               negx_reg;
    logic               negy_reg;
    logic [31:0]        stepx_reg;
    logic [31:0]        stepy_reg;
    logic [31:0]        sidex_reg;
    logic [31:0]        sidey_reg;
    logic [31:0]        len_reg;
    logic               found_reg;
    logic               inmap_reg;
    logic [AW-1:0]      addr_reg;
    logic               out_valid_reg;
    logic [19:0]        out_len_reg;
    logic               out_hit_reg;

    logic       accept;
    logic       cast_start;
    logic       mem_we;
    logic       mem_rdata;
    logic       clearing;
    grd_axis_t  ax;
    grd_axis_t  ay;
    logic [32:0] sum_x;
    logic [32:0] sum_y;
    logic        inmap;
    logic [AW-1:0] addr;

    assign accept     = s_axis_tvalid && s_axis_tready;
    assign cast_start = accept && (s_axis_tuser == CMD_CAST);
    assign mem_we     = accept && (s_axis_tuser == CMD_WRITE)
                        && ({20'd0, s_axis_tdata[11:0]} < DEPTH);
    assign s_axis_tready = (state_reg == S_IDLE) && !clearing;
    assign cfg_ready     = 1'b1;

    assign sum_x = {1'b0, sidex_reg} + {1'b0, stepx_reg};
    assign sum_y = {1'b0, sidey_reg} + {1'b0, stepy_reg};

    assign inmap = !cx_reg[15] && !cy_reg[15]
                   && (cx_reg[14:0] < 15'(cols_reg))
                   && (cy_reg[14:0] < 15'(rows_reg));
    assign addr  = AW'(cy_reg[RW-1:0] * cols_reg) + AW'(cx_reg[CW-1:0]);

    grd_axis u_axis_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cast_start),
        .pos       (s_axis_tdata[32:13]),
        .cell_size (cell_width_reg),
        .dir       (s_axis_tdata[68:53]),
        .res       (ax)
    );

    grd_axis u_axis_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cast_start),
        .pos       (s_axis_tdata[52:33]),
        .cell_size (cell_height_reg),
        .dir       (s_axis_tdata[84:69]),
        .res       (ay)
    );

    grd_tile_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_tile_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .we       (mem_we),
        .waddr    (AW'(s_axis_tdata[11:0])),
        .wdata    (s_axis_tdata[12]),
        .re       (state_reg == S_READ),
        .raddr    (addr_reg),
        .rdata    (mem_rdata),
        .clearing (clearing)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_width_reg  <= 9'd32;
            cell_height_reg <= 9'd32;
            map_columns_reg <= 7'd16;
            map_rows_reg    <= 7'd16;
            max_length_reg  <= 20'd128000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CELL_WIDTH:  cell_width_reg  <= cfg_data[8:0];
                REG_CELL_HEIGHT: cell_height_reg <= cfg_data[8:0];
                REG_MAP_COLUMNS: map_columns_reg <= cfg_data[6:0];
                REG_MAP_ROWS:    map_rows_reg    <= cfg_data[6:0];
                REG_MAX_LENGTH:  max_length_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_OUT && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cast_start)
                    begin
                        state_reg <= S_SETUP;
                    end
                end
                S_SETUP:
                begin
                    if (!ax.busy && !ay.busy)
                    begin
                        state_reg <= S_TEST;
                    end
                end
                S_TEST:
                begin
                    if (found_reg || len_reg >= {12'd0, max_reg})
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_STEP;
                    end
                end
                S_STEP:  state_reg <= S_ADDR;
                S_ADDR:  state_reg <= S_READ;
                S_READ:  state_reg <= S_CHECK;
                S_CHECK: state_reg <= S_TEST;
                S_OUT:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cols_reg <= (map_columns_reg > MAX_COLUMNS) ? CLW'(MAX_COLUMNS)
                                                            : CLW'(map_columns_reg);
                rows_reg <= (map_rows_reg > MAX_ROWS) ? RLW'(MAX_ROWS)
                                                      : RLW'(map_rows_reg);
                max_reg  <= max_length_reg;
            end
            S_SETUP:
            begin
                cx_reg    <= signed'({4'd0, ax.origin});
                cy_reg    <= signed'({4'd0, ay.origin});
                negx_reg  <= ax.neg;
                negy_reg  <= ay.neg;
                stepx_reg <= ax.step;
                stepy_reg <= ay.step;
                sidex_reg <= ax.side;
                sidey_reg <= ay.side;
                len_reg   <= '0;
                found_reg <= 1'b0;
            end
            S_STEP:
            begin
                // ties step on y
                if (sidex_reg < sidey_reg)
                begin
                    cx_reg    <= negx_reg ? cx_reg - 16'sd1 : cx_reg + 16'sd1;
                    len_reg   <= sidex_reg;
                    sidex_reg <= sum_x[32] ? SIDE_MAX : sum_x[31:0];
                end
                else
                begin
                    cy_reg    <= negy_reg ? cy_reg - 16'sd1 : cy_reg + 16'sd1;
                    len_reg   <= sidey_reg;
                    sidey_reg <= sum_y[32] ? SIDE_MAX : sum_y[31:0];
                end
            end
            S_ADDR:
            begin
                inmap_reg <= inmap;
                addr_reg  <= addr;
            end
            S_CHECK:
            begin
                found_reg <= inmap_reg && mem_rdata;
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_len_reg <= (len_reg > {12'd0, LEN_OUT_MAX}) ? LEN_OUT_MAX
                                                                    : len_reg[19:0];
                    out_hit_reg <= found_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, out_hit_reg, out_len_reg};

endmodule
`default_nettype wire

>>> sv/grd_checker.sv
`default_nettype none
module grd_sva_checker
    import grd_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic        cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result item dropped while stalled");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:21] == 3'd0)
        else $error("result padding not zero");

    // a cast needs its divisions before any result can appear
    a_no_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> ##1 !$rose(m_axis_tvalid))
        else $error("result too soon after cast item");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind grid_ray_dda_traversal grd_sva_checker u_grd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_ready     (cfg_ready)
);
`default_nettype wire
